### sv/ntpomd_pkg.sv
// Package for the NTP offset mean/deviation core: payload structs, FSM state
// enum and sizing constants. No dependencies.
package ntpomd_pkg;

	localparam int RING_DEPTH_DEF = 10;
	localparam logic [3:0] WARMUP_RESET = 4'd2;

	typedef struct packed {
		logic        kind;
		logic [63:0] local_send_time;
		logic [63:0] server_receive_time;
		logic [63:0] server_transmit_time;
		logic [63:0] local_receive_time;
	} in_word_t;

	typedef struct packed {
		logic               send_request;
		logic               measurement_valid;
		logic signed [63:0] mean_offset;
		logic [62:0]        std_dev;
		logic [3:0]         entries_used;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_SQ,
		ST_SQMUL,
		ST_VDIV,
		ST_ROOT,
		ST_RMUL,
		ST_OUT
	} state_t;

	localparam logic KIND_POLL = 1'b0;

endpackage

### sv/ntp_offset_mean_deviation_core.sv
// NTP offset filter: one result word per accepted word, one word in flight.
// Poll or discarded response: result the cycle after accept.
// Measured response: a pass over the ring, a mean divide, squared deviations of the
// non-zero entries, a variance divide and a square root on the bit-serial divider and
// multiplier; saturation skips the root, an empty ring goes straight to the result.
// arst_n clears control, the ring (to empty), position; warm-up count loads two.
module ntp_offset_mean_deviation_core #(
	parameter int RING_DEPTH = ntpomd_pkg::RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ntpomd_pkg::in_word_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ntpomd_pkg::out_word_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_data
);
	import ntpomd_pkg::*;

	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int NW = $clog2(RING_DEPTH + 1);

	state_t state_q, state_d;

	logic [3:0]    warmup_q;
	logic [3:0]    discards_q;
	logic [63:0]   ring_q [RING_DEPTH];
	logic [PW-1:0] pos_q;
	logic [PW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic [69:0]   sum_q;    // signed sum, wide enough for 64 entries
	logic [191:0]  sq_acc_q;
	logic [63:0]   mean_q;
	logic          neg_q;
	logic [127:0]  var_q;
	logic [62:0]   root_q;
	logic [5:0]    bit_q;
	logic          sat_q;
	out_word_t     res_q;
	logic          res_valid_q;

	// offset = floor((d1 + d2) / 2)
	logic [63:0] d1, d2, offset;
	assign d1 = in_data.server_receive_time - in_data.local_send_time;
	assign d2 = in_data.server_transmit_time - in_data.local_receive_time;
	assign offset = {d1[63], d1[63:1]} + {d2[63], d2[63:1]} + {63'd0, d1[0] & d2[0]};

	logic accept;
	assign in_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	logic measure;
	assign measure = accept && in_data.kind != KIND_POLL && discards_q == 4'd0;

	// shared divider and multiplier
	logic         div_start, div_done;
	logic [191:0] div_in, div_q;
	logic         mul_start, mul_done;
	logic [63:0]  mul_a;
	logic [127:0] mul_p;

	ntpomd_serdiv u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in),
		.divisor(7'(n_q)), .done(div_done), .quotient(div_q)
	);
	ntpomd_sermul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_a),
		.done(mul_done), .prod(mul_p)
	);

	logic [63:0] cur;
	logic        last_idx;
	assign cur = ring_q[idx_q];
	assign last_idx = (idx_q == PW'(RING_DEPTH - 1));

	logic [69:0] sum_mag;
	assign sum_mag = sum_q[69] ? (~sum_q + 70'd1) : sum_q;

	logic [63:0] dev;
	assign dev = ($signed(cur) >= $signed(mean_q)) ? cur - mean_q : mean_q - cur;

	logic [63:0] cand;
	assign cand = {1'b0, root_q} | (64'd1 << bit_q);

	logic div_is_var_q;

	always_comb begin
		div_start = 1'b0;
		div_in    = '0;
		mul_start = 1'b0;
		mul_a     = '0;
		if (state_q == ST_SUM && last_idx && n_q != '0 + NW'(cur != 0)) begin
			div_start = 1'b0;
		end
		if (state_q == ST_DIV && !div_is_var_q) begin
			div_start = 1'b0;
		end
		case (state_q)
			ST_SQ:    mul_a = dev;
			ST_ROOT:  mul_a = cand;
			default:  mul_a = '0;
		endcase
		if (state_q == ST_SQ && cur != 64'd0) mul_start = 1'b1;
		if (state_q == ST_ROOT) mul_start = 1'b1;
		if (state_q == ST_DIV) begin
			div_start = 1'b1;
			div_in    = {122'd0, sum_mag};
		end
		if (state_q == ST_VDIV) begin
			div_start = 1'b1;
			div_in    = sq_acc_q;
		end
	end

	// next state
	logic wait_q;
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (measure) state_d = ST_SUM;
			ST_SUM:   if (last_idx) state_d = (n_q + NW'(cur != 0) == '0) ? ST_OUT : ST_DIV;
			ST_DIV:   state_d = ST_SQMUL;
			ST_SQ:    state_d = (cur != 64'd0) ? ST_SQMUL : (last_idx ? ST_VDIV : ST_SQ);
			ST_SQMUL: begin
				if (!div_is_var_q && wait_q && div_done) state_d = ST_SQ;
				else if (div_is_var_q && wait_q && div_done)
					state_d = ST_ROOT;
				else if (!wait_q && mul_done)
					state_d = last_idx ? ST_VDIV : ST_SQ;
			end
			ST_VDIV:  state_d = ST_SQMUL;
			ST_ROOT:  state_d = sat_q ? ST_OUT : ST_RMUL;
			ST_RMUL:  if (mul_done) state_d = (bit_q == 6'd0) ? ST_OUT : ST_ROOT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			warmup_q     <= WARMUP_RESET;
			discards_q   <= '0;
			pos_q        <= '0;
			res_valid_q  <= 1'b0;
			wait_q       <= 1'b0;
			div_is_var_q <= 1'b0;
			for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) warmup_q <= cfg_data;
			if (out_valid && out_ready) res_valid_q <= 1'b0;
			if (accept) begin
				if (in_data.kind == KIND_POLL) begin
					discards_q  <= warmup_q;
					res_valid_q <= 1'b1;
				end else if (discards_q != 4'd0) begin
					discards_q  <= discards_q - 4'd1;
					res_valid_q <= 1'b1;
				end else begin
					ring_q[pos_q] <= offset;
					pos_q <= (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + PW'(1);
				end
			end
			if (state_q == ST_DIV) begin
				wait_q <= 1'b1;
				div_is_var_q <= 1'b0;
			end
			if (state_q == ST_VDIV) begin
				wait_q <= 1'b1;
				div_is_var_q <= 1'b1;
			end
			if (state_q == ST_SQMUL && wait_q && div_done) wait_q <= 1'b0;
			if (state_q == ST_OUT) res_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= '0;
			n_q      <= '0;
			sum_q    <= '0;
			sq_acc_q <= '0;
			res_q    <= '{send_request: 1'b1, measurement_valid: 1'b0,
				mean_offset: '0, std_dev: '0, entries_used: '0};
		end
		unique case (state_q)
			ST_SUM: begin
				if (cur != 64'd0) begin
					sum_q <= sum_q + {{6{cur[63]}}, cur};
					n_q   <= n_q + NW'(1);
				end
				idx_q <= last_idx ? '0 : idx_q + PW'(1);
				if (last_idx) begin
					res_q <= '{send_request: 1'b0, measurement_valid: 1'b1,
						mean_offset: '0, std_dev: '0, entries_used: '0};
				end
			end
			// sum is complete here
			ST_DIV: neg_q <= sum_q[69];
			ST_SQ: if (cur == 64'd0) idx_q <= last_idx ? '0 : idx_q + PW'(1);
			ST_SQMUL: begin
				if (wait_q && div_done && !div_is_var_q) begin
					mean_q <= neg_q ? 64'd0 - div_q[63:0] : div_q[63:0];
					idx_q  <= '0;
				end else if (wait_q && div_done && div_is_var_q) begin
					sat_q  <= (div_q[191:126] != 66'd0);
					var_q  <= div_q[127:0];
					root_q <= '0;
					bit_q  <= 6'd62;
				end else if (!wait_q && mul_done) begin
					sq_acc_q <= sq_acc_q + {64'd0, mul_p};
					idx_q    <= last_idx ? '0 : idx_q + PW'(1);
				end
			end
			ST_RMUL: if (mul_done) begin
				if (mul_p <= var_q) root_q <= cand[62:0];
				if (bit_q != 6'd0) bit_q <= bit_q - 6'd1;
			end
			ST_OUT: begin
				res_q.entries_used <= 4'(n_q);
				if (n_q != '0) begin
					res_q.mean_offset <= mean_q;
					res_q.std_dev     <= sat_q ? {63{1'b1}} : root_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

`ifndef SYNTHESIS
	// a result word is never held while a new word is taken
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !in_ready) else $error("accept while result pending");
	// computing states only follow a measured response
	a_sum_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && $past(state_q) == ST_IDLE) |-> $past(measure))
		else $error("sum pass without measurement");
	// poll loads the discard count from the register
	a_poll_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.kind == KIND_POLL) |=> discards_q == $past(warmup_q))
		else $error("discard count not loaded");
`endif
endmodule

### sv/ntpomd_serdiv.sv
// Bit-serial restoring divider: 192-bit dividend by 7-bit divisor, one
// quotient bit per cycle; quotient is complete in the done cycle. No dependencies.
module ntpomd_serdiv (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [191:0] dividend,
	input  logic [6:0]   divisor,
	output logic         done,
	output logic [191:0] quotient
);
	logic [191:0] q_q;
	logic [6:0]   rem_q;
	logic [7:0]   cnt_q;
	logic         busy_q;
	logic [7:0]   trial;
	logic [8:0]   diff;

	assign trial = {rem_q, q_q[191]};
	assign diff = {1'b0, trial} - {2'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 8'd192;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[8]) begin
				rem_q <= diff[6:0];
				q_q   <= {q_q[190:0], 1'b1};
			end else begin
				rem_q <= trial[6:0];
				q_q   <= {q_q[190:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 8'd1);
	// last quotient bit joins combinationally
	assign quotient = {q_q[190:0], ~diff[8]};
endmodule

### sv/ntpomd_sermul.sv
// Shift-add multiplier: 64x64 unsigned product, two multiplier bits per cycle.
// Depends on nothing but its ports.
module ntpomd_sermul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [127:0] acc_q;
	logic [127:0] mcand_q;
	logic [63:0]  mplier_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic [127:0] pp;

	always_comb begin
		pp = acc_q;
		if (mplier_q[0]) pp = pp + mcand_q;
		if (mplier_q[1]) pp = pp + {mcand_q[126:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32 - 6'd1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {64'd0, a};
			mplier_q <= b;
		end else if (busy_q) begin
			acc_q    <= pp;
			mcand_q  <= {mcand_q[125:0], 2'b00};
			mplier_q <= {2'b00, mplier_q[63:2]};
		end
	end

	assign done = busy_q && (cnt_q == 6'd0);
	assign prod = pp;
endmodule

### tb/ntp_offset_mean_deviation_core_test.sv
// Self-checking bench for ntp_offset_mean_deviation_core: directed table, then random
// poll/response sequences. Depends on ntpomd_pkg and the core RTL only.
module ntp_offset_mean_deviation_core_test;
	import ntpomd_pkg::*;

	typedef struct {
		in_word_t  word;
		bit        known;     // expected result typed in below
		out_word_t result;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [3:0] cfg_data;

	// shadow of the core: register, warm-up count, offset ring
	logic [3:0]  warmup_setting;
	logic [3:0]  discards_pending;
	logic [63:0] offset_store [RING_DEPTH_DEF];
	int          store_pos;

	out_word_t   expected_results[$];
	row_t        rows[$];
	int          errors;
	bit          quiet;   // phase without idling on either side

	ntp_offset_mean_deviation_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling on the run time
	initial begin
		#100000000;
		$display("ntp_offset_mean_deviation_core_test: FAIL");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic out_word_t idle_word(input logic req, input logic vld);
		out_word_t r;
		r = '0;
		r.send_request = req;
		r.measurement_valid = vld;
		return r;
	endfunction

	// Mean and deviation over the non-zero ring entries after storing off.
	function automatic out_word_t offset_stats(input logic [63:0] off);
		out_word_t          r;
		logic signed [127:0] total;
		logic signed [127:0] count;
		logic signed [127:0] quot;
		logic signed [64:0]  diff;
		logic [63:0]         mag;
		logic [63:0]         mean;
		logic [159:0]        sqsum;
		logic [159:0]        var_q;
		logic [127:0]        cand_sq;
		logic [63:0]         root;
		logic [63:0]         cand;
		int                  n;
		offset_store[store_pos] = off;
		store_pos = (store_pos + 1) % RING_DEPTH_DEF;
		total = 0;
		n = 0;
		foreach (offset_store[i]) begin
			if (offset_store[i] != 0) begin
				total += $signed(offset_store[i]);
				n++;
			end
		end
		if (n == 0)
			return idle_word(1'b0, 1'b1);
		count = n;
		quot = total / count;  // truncates toward zero
		mean = quot[63:0];
		sqsum = 0;
		foreach (offset_store[i]) begin
			if (offset_store[i] != 0) begin
				diff = $signed({offset_store[i][63], offset_store[i]}) - $signed({mean[63], mean});
				mag = diff[64] ? 64'(-diff) : diff[63:0];
				sqsum += 160'(128'(mag) * 128'(mag));
			end
		end
		var_q = sqsum / 160'(n);
		if (var_q >= (160'd1 << 126)) begin
			root = 64'h7FFF_FFFF_FFFF_FFFF;
		end else begin
			root = 0;
			for (int b = 62; b >= 0; b--) begin
				cand = root | (64'd1 << b);
				cand_sq = 128'(cand) * 128'(cand);
				if (160'(cand_sq) <= var_q)
					root = cand;
			end
		end
		r = idle_word(1'b0, 1'b1);
		r.mean_offset = mean;
		r.std_dev = root[62:0];
		r.entries_used = n[3:0];
		return r;
	endfunction

	function automatic out_word_t filter_step(input in_word_t w);
		logic [63:0]        d1;
		logic [63:0]        d2;
		logic signed [64:0] sum;
		if (w.kind == KIND_POLL) begin
			discards_pending = warmup_setting;
			return idle_word(1'b1, 1'b0);
		end
		if (discards_pending != 0) begin
			discards_pending--;
			return idle_word(1'b1, 1'b0);
		end
		d1 = w.server_receive_time - w.local_send_time;
		d2 = w.server_transmit_time - w.local_receive_time;
		sum = $signed({d1[63], d1}) + $signed({d2[63], d2});
		return offset_stats(sum[64:1]);  // floor of half
	endfunction

	function automatic in_word_t resp(input logic [63:0] t1, t2, t3, t4);
		in_word_t w;
		w.kind = ~KIND_POLL;
		w.local_send_time = t1;
		w.server_receive_time = t2;
		w.server_transmit_time = t3;
		w.local_receive_time = t4;
		return w;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_word_t poll_word(input bit noisy);
		in_word_t w;
		w = noisy ? resp(rand64(), rand64(), rand64(), rand64()) : '0;
		w.kind = KIND_POLL;
		return w;
	endfunction

	// Plausible exchange: small path delay, offset of a few ms either way.
	function automatic in_word_t sane_resp();
		logic [63:0] t1;
		logic [63:0] dly;
		logic [63:0] off;
		logic [63:0] hold;
		t1 = rand64();
		dly = 64'($urandom_range(0, 32'h0FFF_FFFF));
		off = 64'($signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh01FF_FFFF);
		hold = 64'($urandom_range(0, 32'h00FF_FFFF));
		return resp(t1, t1 + dly + off, t1 + dly + off + hold, t1 + 2 * dly + hold);
	endfunction

	task automatic add_row(input in_word_t w, input bit known, input out_word_t r);
		row_t x;
		x.word = w;
		x.known = known;
		x.result = r;
		rows.push_back(x);
	endtask

	// Drive one word, hold it until taken, then predict. Gap after is random unless quiet.
	task automatic send_word(input in_word_t w, input bit known, input out_word_t r);
		out_word_t p;
		int        gap;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		p = filter_step(w);
		if (known && p != r)
			report("table row vs predictor", p[63:0], r[63:0]);
		expected_results.push_back(known ? r : p);
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// Register write; only ever called with the core idle.
	task automatic write_warmup(input logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		warmup_setting = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: random back-pressure, in-order check against the queue.
	initial begin : result_side
		out_word_t want;
		int        stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result word", out_data[63:0], 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.send_request !== want.send_request)
						report("send_request", 64'(out_data.send_request), 64'(want.send_request));
					if (out_data.measurement_valid !== want.measurement_valid)
						report("measurement_valid", 64'(out_data.measurement_valid),
							64'(want.measurement_valid));
					if (out_data.mean_offset !== want.mean_offset)
						report("mean_offset", out_data.mean_offset, want.mean_offset);
					if (out_data.std_dev !== want.std_dev)
						report("std_dev", 64'(out_data.std_dev), 64'(want.std_dev));
					if (out_data.entries_used !== want.entries_used)
						report("entries_used", 64'(out_data.entries_used), 64'(want.entries_used));
				end
				stall = quiet ? 0 : $urandom_range(0, 9);
				if (stall != 0)
					out_ready <= 1'b0;
			end else if (!out_ready && arst_n) begin
				if (stall > 0)
					stall--;
				if (stall == 0)
					out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [63:0] max64;
		logic [63:0] pos_max;
		logic [63:0] neg_min;
		out_word_t   r;
		logic [3:0]  phase_cfg [6];
		int          sent;
		int          burst;
		errors = 0;
		quiet = 1'b0;
		warmup_setting = WARMUP_RESET;
		discards_pending = '0;
		store_pos = 0;
		foreach (offset_store[i])
			offset_store[i] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		out_ready <= 1'b1;
		@(posedge clk);

		max64 = '1;
		pos_max = 64'h7FFF_FFFF_FFFF_FFFF;
		neg_min = 64'h8000_0000_0000_0000;
		// empty ring straight out of reset: zero offset measures as nothing
		add_row(resp('0, '0, '0, '0), 1'b1, idle_word(1'b0, 1'b1));
		// poll loads the reset warm-up count of two
		add_row(poll_word(1'b1), 1'b1, idle_word(1'b1, 1'b0));
		add_row(resp(max64, max64, max64, max64), 1'b1, idle_word(1'b1, 1'b0));
		add_row(resp('0, max64, '0, max64), 1'b1, idle_word(1'b1, 1'b0));
		// half a second, one entry
		r = idle_word(1'b0, 1'b1);
		r.mean_offset = 64'h0000_0000_8000_0000;
		r.entries_used = 4'd1;
		add_row(resp('0, 64'h1_0000_0000, 64'd7, 64'd7), 1'b1, r);
		add_row(resp('0, max64, max64, '0), 1'b0, r);          // -1 lsb
		add_row(resp('0, pos_max, pos_max, '0), 1'b0, r);      // largest offset
		add_row(resp('0, neg_min, neg_min, '0), 1'b0, r);      // most negative offset
		add_row(resp(max64, '0, '0, max64), 1'b0, r);
		add_row(resp(64'd5, 64'd5, 64'd9, 64'd9), 1'b0, r);    // zero offset stored
		add_row(resp(64'd0, 64'd1, 64'd0, 64'd0), 1'b0, r);    // odd sum rounds down
		add_row(resp(64'd1, 64'd0, 64'd0, 64'd0), 1'b0, r);
		add_row(resp(neg_min, '0, pos_max, max64), 1'b0, r);
		for (int i = 0; i < 6; i++)
			add_row(sane_resp(), 1'b0, r);                       // fills and wraps ring
		add_row(poll_word(1'b0), 1'b1, idle_word(1'b1, 1'b0));
		foreach (rows[i])
			send_word(rows[i].word, rows[i].known, rows[i].result);
		in_valid <= 1'b0;
		drain();

		phase_cfg[0] = 4'd0;
		phase_cfg[1] = 4'd15;
		phase_cfg[2] = 4'd1;
		phase_cfg[3] = 4'($urandom_range(0, 15));
		phase_cfg[4] = 4'd0;
		phase_cfg[5] = 4'($urandom_range(0, 15));
		foreach (phase_cfg[p]) begin
			write_warmup(phase_cfg[p]);
			quiet = (p == 2);
			sent = 0;
			while (sent < 105) begin
				case ($urandom_range(0, 9))
					0: begin
						send_word(resp(rand64(), rand64(), rand64(), rand64()), 1'b0, r);
						sent++;
					end
					1: begin
						send_word(poll_word(1'b1), 1'b0, r);
						sent++;
					end
					default: begin
						// poll, warm-up discards, then a burst of measurements
						send_word(poll_word(1'($urandom_range(0, 1))), 1'b0, r);
						for (int k = 0; k < phase_cfg[p]; k++)
							send_word(sane_resp(), 1'b0, r);
						burst = $urandom_range(1, 8);
						for (int k = 0; k < burst; k++) begin
							if ($urandom_range(0, 7) == 0)
								send_word(resp(rand64(), rand64(), rand64(), rand64()), 1'b0, r);
							else
								send_word(sane_resp(), 1'b0, r);
						end
						sent += 1 + phase_cfg[p] + burst;
					end
				endcase
			end
			in_valid <= 1'b0;
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ntp_offset_mean_deviation_core_test: PASS");
		else
			$display("ntp_offset_mean_deviation_core_test: FAIL");
		$finish;
	end

endmodule

### sim.f
sv/ntpomd_pkg.sv
sv/ntpomd_serdiv.sv
sv/ntpomd_sermul.sv
sv/ntp_offset_mean_deviation_core.sv
tb/ntp_offset_mean_deviation_core_test.sv
